// ===== design/cbq_pkg.sv =====
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared constants, control-word types and the microcode table of the
// cascaded biquad filter.
// ----------------------------------------------------------------------------
package cbq_pkg;

    // parameter defaults
    localparam int SECTIONS_DEF       = 4;
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 20;

    // fixed field widths
    localparam int COEF_WIDTH  = 24;
    localparam int DELAY_WIDTH = 32;
    localparam int SLOTS       = 5;
    localparam int SECTION_W   = 2;
    localparam int SLOT_W      = 3;
    localparam int COUNT_W     = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 3;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SECTION_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_ON_WRITE = 2'd1;

    // coefficient slots
    localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

    // delay register select within a section
    localparam logic DLY_D0 = 1'b0;
    localparam logic DLY_D1 = 1'b1;

    // multiplier operand
    localparam logic SRC_X = 1'b0;
    localparam logic SRC_Y = 1'b1;

    typedef logic [1:0] acc_base_t;
    localparam acc_base_t BASE_ZERO = 2'd0;
    localparam acc_base_t BASE_ACC  = 2'd1;
    localparam acc_base_t BASE_DLY  = 2'd2;

    typedef logic [1:0] acc_term_t;
    localparam acc_term_t TERM_NONE = 2'd0;
    localparam acc_term_t TERM_ADD  = 2'd1;
    localparam acc_term_t TERM_SUB  = 2'd2;

    typedef logic [1:0] jump_t;
    localparam jump_t JMP_NONE          = 2'd0;
    localparam jump_t JMP_NO_SECTIONS   = 2'd1;
    localparam jump_t JMP_MORE_SECTIONS = 2'd2;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    // program entry points and jump targets
    localparam pc_t PC_SAMPLE  = 4'd0;
    localparam pc_t PC_SECTION = 4'd1;
    localparam pc_t PC_DONE    = 4'd10;
    localparam pc_t PC_COEF    = 4'd11;

    typedef struct packed {
        logic      mul_en;
        logic      mul_src;
        acc_base_t acc_base;
        acc_term_t acc_term;
        logic      y_ld;
        logic      x_from_y;
    } dp_ctl_t;

    localparam dp_ctl_t DP_HOLD = '{
        mul_en:   1'b0,
        mul_src:  SRC_X,
        acc_base: BASE_ACC,
        acc_term: TERM_NONE,
        y_ld:     1'b0,
        x_from_y: 1'b0
    };

    typedef struct packed {
        dp_ctl_t           dp;
        logic              coef_rd;
        logic [SLOT_W-1:0] coef_rslot;
        logic              dly_rd;
        logic              dly_rsel;
        logic              dly_wr;
        logic              dly_wsel;
        logic              coef_wr;
        logic              out_ld;
        jump_t             jump;
        pc_t               target;
        logic              last;
    } ctl_word_t;

    // One section is steps 1..9. Memory reads are registered, and
    // the read data holds until the next read on that port.
    function automatic ctl_word_t microcode(pc_t pc);
        ctl_word_t w;
        w            = '0;
        w.dp         = DP_HOLD;
        w.coef_rslot = SLOT_B0;
        w.jump       = JMP_NONE;
        w.target     = PC_SAMPLE;
        case (pc)
            4'd0:
            begin
                w.jump   = JMP_NO_SECTIONS;
                w.target = PC_DONE;
            end
            4'd1:
            begin
                w.coef_rd    = 1'b1;
                w.coef_rslot = SLOT_B0;
                w.dly_rd     = 1'b1;
                w.dly_rsel   = DLY_D0;
            end
            4'd2:
            begin
                // acc = d0, prod = b0*x
                w.dp.mul_en   = 1'b1;
                w.dp.mul_src  = SRC_X;
                w.dp.acc_base = BASE_DLY;
                w.coef_rd     = 1'b1;
                w.coef_rslot  = SLOT_B1;
                w.dly_rd      = 1'b1;
                w.dly_rsel    = DLY_D1;
            end
            4'd3:
            begin
                // acc = d0 + rnd(b0*x), prod = b1*x
                w.dp.mul_en   = 1'b1;
                w.dp.mul_src  = SRC_X;
                w.dp.acc_term = TERM_ADD;
                w.coef_rd     = 1'b1;
                w.coef_rslot  = SLOT_A1;
            end
            4'd4:
            begin
                // y = sat(acc), acc = d1 + rnd(b1*x)
                w.dp.y_ld     = 1'b1;
                w.dp.acc_base = BASE_DLY;
                w.dp.acc_term = TERM_ADD;
            end
            4'd5:
            begin
                w.dp.mul_en  = 1'b1;
                w.dp.mul_src = SRC_Y;
                w.coef_rd    = 1'b1;
                w.coef_rslot = SLOT_B2;
            end
            4'd6:
            begin
                w.dp.mul_en   = 1'b1;
                w.dp.mul_src  = SRC_X;
                w.dp.acc_term = TERM_SUB;
                w.coef_rd     = 1'b1;
                w.coef_rslot  = SLOT_A2;
            end
            4'd7:
            begin
                // new d0 out, acc = rnd(b2*x), prod = a2*y
                w.dly_wr      = 1'b1;
                w.dly_wsel    = DLY_D0;
                w.dp.mul_en   = 1'b1;
                w.dp.mul_src  = SRC_Y;
                w.dp.acc_base = BASE_ZERO;
                w.dp.acc_term = TERM_ADD;
            end
            4'd8:
            begin
                w.dp.acc_term = TERM_SUB;
            end
            4'd9:
            begin
                w.dly_wr      = 1'b1;
                w.dly_wsel    = DLY_D1;
                w.dp.x_from_y = 1'b1;
                w.jump        = JMP_MORE_SECTIONS;
                w.target      = PC_SECTION;
            end
            4'd10:
            begin
                w.out_ld = 1'b1;
                w.last   = 1'b1;
            end
            4'd11:
            begin
                w.coef_wr = 1'b1;
                w.last    = 1'b1;
            end
            default:
            begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== design/cascaded_biquad_iir_filter.sv =====
// ----------------------------------------------------------------------------
// cascaded_biquad_iir_filter
// Cascade of second-order IIR sections, direct form II transposed, run by a
// microcoded sequencer over one shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
// A sample transfer occupies the block through all N active sections, N being the number
// of active sections (section_count clamped to SECTIONS, possibly zero): each
// section is a nine-step microprogram that pushes five products through the
// single shared multiplier and reads coefficients and delay state one word
// at a time from the coefficient and delay RAMs. A coefficient transfer runs only
// the write step at PC_COEF. in_ready is high whenever the sequencer is
// idle, also while a finished sample waits in the output register; the final
// step of the next sample holds until that register has been taken. Reset
// values of both stores come from per-entry valid bits, so there is no
// clearing pass after reset. section_count and clear_on_coef_write are
// written through the cfg port, which is always ready.
module cascaded_biquad_iir_filter #(
    parameter int SECTIONS       = cbq_pkg::SECTIONS_DEF,
    parameter int SAMPLE_BITS    = cbq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = cbq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic                                     kind,
    input  logic signed [SAMPLE_BITS-1:0]            sample_in,
    input  logic [cbq_pkg::SECTION_W-1:0]            section,
    input  logic [cbq_pkg::SLOT_W-1:0]               coef_slot,
    input  logic signed [cbq_pkg::COEF_WIDTH-1:0]    coef_value,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [SAMPLE_BITS-1:0]            sample_out,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [cbq_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  logic [cbq_pkg::CFG_DATA_W-1:0]           cfg_data
);

    localparam int CW      = cbq_pkg::COEF_WIDTH;
    localparam int DW      = cbq_pkg::DELAY_WIDTH;
    localparam int CDEPTH  = SECTIONS * cbq_pkg::SLOTS;
    localparam int DDEPTH  = SECTIONS * 2;
    localparam int CADDR_W = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int DADDR_W = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
    localparam int SIDX_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int AC_W    = 8;

    localparam logic signed [CW-1:0] COEF_ONE =
        (COEF_FRAC_BITS < CW - 1) ? (CW'(1) << COEF_FRAC_BITS) : {1'b0, {(CW-1){1'b1}}};

    // configuration
    logic [cbq_pkg::COUNT_W-1:0] section_count_reg;
    logic                        clear_reg;

    // sequencer
    logic                  busy_reg;
    cbq_pkg::pc_t          pc_reg;
    logic [SIDX_W-1:0]     sec_reg;
    cbq_pkg::ctl_word_t    cw;
    logic                  stall;
    logic                  step_en;
    logic                  no_sections;
    logic                  more_sections;
    logic                  jump_taken;
    logic                  accept;

    // latched coefficient item
    logic [cbq_pkg::SECTION_W-1:0] wsec_reg;
    logic [cbq_pkg::SLOT_W-1:0]    wslot_reg;
    logic signed [CW-1:0]          wcoef_reg;

    // stores
    logic [CDEPTH-1:0]     cvalid_reg;
    logic [DDEPTH-1:0]     dvalid_reg;
    logic                  cvld_q_reg;
    logic                  cslot0_q_reg;
    logic                  dvld_q_reg;
    logic [AC_W-1:0]       craddr_full;
    logic [AC_W-1:0]       cwaddr_full;
    logic [AC_W-1:0]       daddr_full;
    logic [AC_W-1:0]       dclr_full;
    logic [CADDR_W-1:0]    craddr;
    logic [CADDR_W-1:0]    cwaddr;
    logic [DADDR_W-1:0]    drwaddr;
    logic [DADDR_W-1:0]    dclr0;
    logic [DADDR_W-1:0]    dclr1;
    logic                  coef_we;
    logic                  coef_re;
    logic                  dly_we;
    logic                  dly_re;
    logic [CW-1:0]         coef_rdata;
    logic [DW-1:0]         dly_rdata;
    logic signed [CW-1:0]  coef_eff;
    logic signed [DW-1:0]  dly_eff;
    logic signed [DW-1:0]  dly_wdata;

    // datapath
    cbq_pkg::dp_ctl_t              dp_ctl;
    logic signed [SAMPLE_BITS-1:0] x_val;

    // output register
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !busy_reg;
    assign cfg_ready = 1'b1;

    assign cw      = cbq_pkg::microcode(pc_reg);
    assign stall   = cw.out_ld && out_valid_reg && !out_ready;
    assign step_en = busy_reg && !stall;

    assign no_sections   = (section_count_reg == '0);
    assign more_sections = ((int'(sec_reg) + 1) < int'(section_count_reg))
                           && ((int'(sec_reg) + 1) < SECTIONS);

    always_comb
    begin
        case (cw.jump)
            cbq_pkg::JMP_NO_SECTIONS:   jump_taken = no_sections;
            cbq_pkg::JMP_MORE_SECTIONS: jump_taken = more_sections;
            default:                    jump_taken = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= cbq_pkg::PC_SAMPLE;
            sec_reg  <= '0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
            pc_reg   <= (kind == cbq_pkg::KIND_COEF) ? cbq_pkg::PC_COEF : cbq_pkg::PC_SAMPLE;
            sec_reg  <= '0;
        end
        else if (step_en)
        begin
            if (cw.last)
            begin
                busy_reg <= 1'b0;
            end
            if (jump_taken)
            begin
                pc_reg <= cw.target;
                if (cw.jump == cbq_pkg::JMP_MORE_SECTIONS)
                begin
                    sec_reg <= SIDX_W'(sec_reg + 1'b1);
                end
            end
            else
            begin
                pc_reg <= cbq_pkg::pc_t'(pc_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wsec_reg  <= section;
            wslot_reg <= coef_slot;
            wcoef_reg <= coef_value;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_count_reg <= cbq_pkg::COUNT_W'(1);
            clear_reg         <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cbq_pkg::REG_SECTION_COUNT:  section_count_reg <= cfg_data[cbq_pkg::COUNT_W-1:0];
                cbq_pkg::REG_CLEAR_ON_WRITE: clear_reg <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // address generation
    assign craddr_full = AC_W'(sec_reg) * AC_W'(cbq_pkg::SLOTS) + AC_W'(cw.coef_rslot);
    assign cwaddr_full = AC_W'(wsec_reg) * AC_W'(cbq_pkg::SLOTS) + AC_W'(wslot_reg);
    assign daddr_full  = (AC_W'(sec_reg) << 1)
                         | AC_W'(cw.dly_wr ? cw.dly_wsel : cw.dly_rsel);
    assign dclr_full   = AC_W'(wsec_reg) << 1;
    assign craddr      = craddr_full[CADDR_W-1:0];
    assign cwaddr      = cwaddr_full[CADDR_W-1:0];
    assign drwaddr     = daddr_full[DADDR_W-1:0];
    assign dclr0       = dclr_full[DADDR_W-1:0];
    assign dclr1       = dclr0 | DADDR_W'(1);

    // out-of-range section or slot writes are dropped
    assign coef_we = step_en && cw.coef_wr && (int'(wsec_reg) < SECTIONS)
                     && (int'(wslot_reg) < cbq_pkg::SLOTS);
    assign coef_re = step_en && cw.coef_rd;
    assign dly_we  = step_en && cw.dly_wr;
    assign dly_re  = step_en && cw.dly_rd;

    cbq_ram #(
        .WIDTH (CW),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (cwaddr),
        .wdata (wcoef_reg),
        .re    (coef_re),
        .raddr (craddr),
        .rdata (coef_rdata)
    );

    cbq_ram #(
        .WIDTH (DW),
        .DEPTH (DDEPTH)
    ) u_delay_ram (
        .clk   (clk),
        .we    (dly_we),
        .waddr (drwaddr),
        .wdata (dly_wdata),
        .re    (dly_re),
        .raddr (drwaddr),
        .rdata (dly_rdata)
    );

    // valid bits stand in for the reset contents of both stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvalid_reg   <= '0;
            dvalid_reg   <= '0;
            cvld_q_reg   <= 1'b0;
            cslot0_q_reg <= 1'b0;
            dvld_q_reg   <= 1'b0;
        end
        else
        begin
            if (coef_we)
            begin
                cvalid_reg[cwaddr] <= 1'b1;
                if (clear_reg)
                begin
                    dvalid_reg[dclr0] <= 1'b0;
                    dvalid_reg[dclr1] <= 1'b0;
                end
            end
            if (dly_we)
            begin
                dvalid_reg[drwaddr] <= 1'b1;
            end
            if (coef_re)
            begin
                cvld_q_reg   <= cvalid_reg[craddr];
                cslot0_q_reg <= (cw.coef_rslot == cbq_pkg::SLOT_B0);
            end
            if (dly_re)
            begin
                dvld_q_reg <= dvalid_reg[drwaddr];
            end
        end
    end

    assign coef_eff = cvld_q_reg ? coef_rdata : (cslot0_q_reg ? COEF_ONE : '0);
    assign dly_eff  = dvld_q_reg ? dly_rdata : '0;

    assign dp_ctl = step_en ? cw.dp : cbq_pkg::DP_HOLD;

    cbq_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .ctl       (dp_ctl),
        .x_ld      (accept),
        .sample_in (sample_in),
        .coef      (coef_eff),
        .dly       (dly_eff),
        .x_val     (x_val),
        .dly_wdata (dly_wdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_en && cw.out_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && cw.out_ld)
        begin
            sample_out_reg <= x_val;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

// ===== design/cbq_ram.sv =====
// ----------------------------------------------------------------------------
// cbq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/cbq_datapath.sv =====
// ----------------------------------------------------------------------------
// cbq_datapath
// Shared multiplier, rounding, accumulator and saturation of the biquad
// sequencer.
// ----------------------------------------------------------------------------
module cbq_datapath #(
    parameter int SAMPLE_BITS    = cbq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = cbq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  cbq_pkg::dp_ctl_t                     ctl,
    input  logic                                 x_ld,
    input  logic signed [SAMPLE_BITS-1:0]        sample_in,
    input  logic signed [cbq_pkg::COEF_WIDTH-1:0]  coef,
    input  logic signed [cbq_pkg::DELAY_WIDTH-1:0] dly,
    output logic signed [SAMPLE_BITS-1:0]        x_val,
    output logic signed [cbq_pkg::DELAY_WIDTH-1:0] dly_wdata
);

    localparam int PW    = cbq_pkg::COEF_WIDTH + SAMPLE_BITS;
    localparam int ACC_W = PW + 2;
    localparam int DW    = cbq_pkg::DELAY_WIDTH;

    localparam logic signed [PW-1:0] RND_HALF =
        {{(PW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] S_MAX =
        ({{(ACC_W-1){1'b0}}, 1'b1} << (SAMPLE_BITS - 1)) - {{(ACC_W-1){1'b0}}, 1'b1};
    localparam logic signed [ACC_W-1:0] S_MIN = -S_MAX - 1;
    localparam logic signed [ACC_W-1:0] D_MAX =
        ({{(ACC_W-1){1'b0}}, 1'b1} << (DW - 1)) - {{(ACC_W-1){1'b0}}, 1'b1};
    localparam logic signed [ACC_W-1:0] D_MIN = -D_MAX - 1;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    logic signed [SAMPLE_BITS-1:0] mul_opnd;
    logic signed [PW-1:0]          prod_next;
    logic signed [PW-1:0]          rnd_val;
    logic signed [ACC_W-1:0]       term;
    logic signed [ACC_W-1:0]       base;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    assign mul_opnd  = (ctl.mul_src == cbq_pkg::SRC_Y) ? y_reg : x_reg;
    assign prod_next = PW'(coef) * PW'(mul_opnd);

    // round half up to the sample scale
    assign rnd_val = (prod_reg + RND_HALF) >>> COEF_FRAC_BITS;
    assign term    = ACC_W'(rnd_val);

    always_comb
    begin
        case (ctl.acc_base)
            cbq_pkg::BASE_ZERO: base = '0;
            cbq_pkg::BASE_DLY:  base = ACC_W'(dly);
            default:            base = acc_reg;
        endcase
        case (ctl.acc_term)
            cbq_pkg::TERM_ADD: acc_next = base + term;
            cbq_pkg::TERM_SUB: acc_next = base - term;
            default:           acc_next = base;
        endcase
    end

    always_comb
    begin
        if (acc_reg > S_MAX)
        begin
            y_sat = S_MAX[SAMPLE_BITS-1:0];
        end
        else if (acc_reg < S_MIN)
        begin
            y_sat = S_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            y_sat = acc_reg[SAMPLE_BITS-1:0];
        end

        if (acc_reg > D_MAX)
        begin
            dly_wdata = D_MAX[DW-1:0];
        end
        else if (acc_reg < D_MIN)
        begin
            dly_wdata = D_MIN[DW-1:0];
        end
        else
        begin
            dly_wdata = acc_reg[DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.y_ld)
        begin
            y_reg <= y_sat;
        end
        if (x_ld)
        begin
            x_reg <= sample_in;
        end
        else if (ctl.x_from_y)
        begin
            x_reg <= y_reg;
        end
    end

    assign x_val = x_reg;

endmodule

// ===== design/cbq_checker.sv =====
// ----------------------------------------------------------------------------
// cbq_checker
// Port-level checks of the cascaded biquad filter, bound to the top level.
// ----------------------------------------------------------------------------
module cbq_checker #(
    parameter int SAMPLE_BITS = cbq_pkg::SAMPLE_BITS_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   kind,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] sample_out
);

    // the sequencer is busy right after any input transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after an input transfer");

    // a coefficient write frees the input after its write step and yields no result
    a_coef_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == cbq_pkg::KIND_COEF)
        |=> ##1 (in_ready && !$rose(out_valid)))
        else $error("coefficient write misbehaved");

    // a new result is loaded by the final step, which frees the input
    a_result_frees_in: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $rose(in_ready))
        else $error("result appeared without the sequencer finishing");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out))
        else $error("stalled result dropped or changed");

endmodule

bind cascaded_biquad_iir_filter cbq_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_cbq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
);

// ===== bench/cascaded_biquad_iir_filter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cascaded_biquad_iir_filter_tb
// Self-checking bench for the biquad cascade. Sample and coefficient
// transfers are fed from a queue by a clocked driver. Each accepted item is
// run through a fixed-point DF2T model of the cascade, and every output
// transfer is checked against the oldest predicted sample. Both handshakes
// see random idle bursts. Section count and state clearing change between
// phases, only while the filter is idle.
// ----------------------------------------------------------------------------
module cascaded_biquad_iir_filter_tb;

    localparam int SECS      = cbq_pkg::SECTIONS_DEF;
    localparam int SB        = cbq_pkg::SAMPLE_BITS_DEF;
    localparam int FRAC      = cbq_pkg::COEF_FRAC_BITS_DEF;
    localparam int CW        = cbq_pkg::COEF_WIDTH;
    localparam int DLW       = cbq_pkg::DELAY_WIDTH;
    localparam int NSLOTS    = cbq_pkg::SLOTS;
    localparam int IDX_W     = cbq_pkg::CFG_INDEX_W;
    localparam int DAT_W     = cbq_pkg::CFG_DATA_W;
    localparam int SEC_W     = cbq_pkg::SECTION_W;
    localparam int SL_W      = cbq_pkg::SLOT_W;
    localparam int HANG_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 500;

    // register indexes and slots that the filter has no use for
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam logic [SL_W-1:0] SLOT_BAD_LO = 3'd5;
    localparam logic [SL_W-1:0] SLOT_BAD_HI = 3'd7;

    typedef struct packed {
        logic             kind;
        logic [SB-1:0]    sample;
        logic [SEC_W-1:0] section;
        logic [SL_W-1:0]  slot;
        logic [CW-1:0]    value;
    } filt_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          kind = cbq_pkg::KIND_SAMPLE;
    logic signed [SB-1:0]          sample_in = '0;
    logic [SEC_W-1:0]              section = '0;
    logic [SL_W-1:0]               coef_slot = cbq_pkg::SLOT_B0;
    logic signed [CW-1:0]          coef_value = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [SB-1:0]          sample_out;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [IDX_W-1:0]              cfg_index = cbq_pkg::REG_SECTION_COUNT;
    logic [DAT_W-1:0]              cfg_data = '0;

    // filter model state
    logic signed [CW-1:0]          taps [0:SECS-1][0:NSLOTS-1];
    logic signed [DLW-1:0]         dly_state [0:SECS-1][0:1];
    logic [cbq_pkg::COUNT_W-1:0]   sec_count;
    logic                          clear_on_write;

    filt_item_t       pending_items[$];
    logic [SB-1:0]    expected_samples[$];
    filt_item_t       drv_item;
    logic             item_held = 1'b0;
    logic             calm = 1'b0;
    int               gap_left = 0;
    int               stall_left = 0;
    int               errors = 0;
    int               idle_cycles = 0;
    int               fed = 0;

    cascaded_biquad_iir_filter DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .sample_in  (sample_in),
        .section    (section),
        .coef_slot  (coef_slot),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #6 clk = ~clk;

    task automatic note_error(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // coefficient times sample, round half up back to the sample scale
    function automatic longint scale_product(input longint c, input longint x);
        return (c * x + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic logic [SB-1:0] run_cascade(input logic [SB-1:0] raw);
        longint x;
        longint y;
        int     n;
        int     s;
        x = longint'($signed(raw));
        n = (sec_count > SECS) ? SECS : int'(sec_count);
        for (s = 0; s < n; s++)
        begin
            y = clamp(scale_product(taps[s][cbq_pkg::SLOT_B0], x) + dly_state[s][0], SB);
            dly_state[s][0] = DLW'(clamp(scale_product(taps[s][cbq_pkg::SLOT_B1], x)
                                         - scale_product(taps[s][cbq_pkg::SLOT_A1], y)
                                         + dly_state[s][1], DLW));
            dly_state[s][1] = DLW'(clamp(scale_product(taps[s][cbq_pkg::SLOT_B2], x)
                                         - scale_product(taps[s][cbq_pkg::SLOT_A2], y), DLW));
            x = y;
        end
        return x[SB-1:0];
    endfunction

    function automatic void apply_item(input filt_item_t it);
        logic [SB-1:0] predicted;
        if (it.kind == cbq_pkg::KIND_COEF)
        begin
            if (it.slot < NSLOTS && it.section < SECS)
            begin
                taps[it.section][it.slot] = it.value;
                if (clear_on_write)
                begin
                    dly_state[it.section][0] = '0;
                    dly_state[it.section][1] = '0;
                end
            end
        end
        else
        begin
            predicted = run_cascade(it.sample);
            expected_samples = {expected_samples, predicted};
        end
    endfunction

    // driver: one item held on the input channel until its transfer
    always @(posedge clk)
    begin : drive_items
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_item(drv_item);
                item_held = 1'b0;
            end
            if (!item_held)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    drv_item = pending_items.pop_front();
                    item_held = 1'b1;
                    kind       <= drv_item.kind;
                    sample_in  <= drv_item.sample;
                    section    <= drv_item.section;
                    coef_slot  <= drv_item.slot;
                    coef_value <= drv_item.value;
                    in_valid   <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 8);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check every output transfer, stall out_ready in bursts
    always @(posedge clk)
    begin : check_outputs
        logic [SB-1:0] want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    note_error($sformatf("unexpected output %0d", sample_out));
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample_out !== want)
                        note_error($sformatf("sample_out %0d, expected %0d",
                                             sample_out, $signed(want)));
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 4) == 0)
                    stall_left = $urandom_range(1, 8);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [DAT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == cbq_pkg::REG_SECTION_COUNT)
            sec_count = val;
        else if (idx == cbq_pkg::REG_CLEAR_ON_WRITE)
            clear_on_write = val[0];
        cfg_valid <= 1'b0;
    endtask

    // wait until every item is taken and every output seen; a coefficient
    // transfer still runs its write step after its acceptance
    task automatic drain();
        while (pending_items.size() != 0 || item_held || expected_samples.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic void queue_sample(input int x);
        filt_item_t it;
        it.kind    = cbq_pkg::KIND_SAMPLE;
        it.sample  = SB'(x);
        it.section = SEC_W'($urandom);
        it.slot    = SL_W'($urandom);
        it.value   = CW'($urandom);
        pending_items = {pending_items, it};
    endfunction

    function automatic void queue_coef(input int sec, input logic [SL_W-1:0] slot,
                                       input int val);
        filt_item_t it;
        it.kind    = cbq_pkg::KIND_COEF;
        it.sample  = SB'($urandom);
        it.section = SEC_W'(sec);
        it.slot    = slot;
        it.value   = CW'(val);
        pending_items = {pending_items, it};
    endfunction

    function automatic int pick_sample();
        case ($urandom_range(0, 3))
            0: return int'($urandom);
            1: return $urandom_range(0, 1) ? 32767 : -32768;
            default: return int'($urandom_range(0, 8000)) - 4000;
        endcase
    endfunction

    function automatic int coef_around(input int mag);
        return int'($urandom_range(0, 2 * mag)) - mag;
    endfunction

    // a stable-ish section: |a2| < 0.9, |a1| inside the stability triangle
    function automatic void program_section(input int sec);
        int a2;
        int lim;
        a2  = coef_around(943718);
        lim = ((1 << FRAC) + a2) / 100 * 95;
        queue_coef(sec, cbq_pkg::SLOT_B0, coef_around(1 << FRAC));
        queue_coef(sec, cbq_pkg::SLOT_B1, coef_around(1 << FRAC));
        queue_coef(sec, cbq_pkg::SLOT_B2, coef_around(1 << FRAC));
        queue_coef(sec, cbq_pkg::SLOT_A1, coef_around(lim));
        queue_coef(sec, cbq_pkg::SLOT_A2, a2);
    endfunction

    // any field pattern; returns 0 for a write that is dropped
    function automatic int noise_item();
        filt_item_t  it;
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        it = bits[$bits(filt_item_t)-1:0];
        pending_items = {pending_items, it};
        return (it.kind == cbq_pkg::KIND_COEF && it.slot >= NSLOTS) ? 0 : 1;
    endfunction

    initial
    begin : stimulus
        int s;
        int r;
        int cnt;
        for (s = 0; s < SECS; s++)
        begin
            for (r = 0; r < NSLOTS; r++)
                taps[s][r] = (r == cbq_pkg::SLOT_B0) ? CW'(1 << FRAC) : '0;
            dly_state[s][0] = '0;
            dly_state[s][1] = '0;
        end
        sec_count = 1;
        clear_on_write = 1'b1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset state is a single unity section
        queue_sample(32767);
        queue_sample(-32768);
        queue_sample(0);
        queue_sample(-1);
        drain();

        // no sections: straight through
        write_reg(cbq_pkg::REG_SECTION_COUNT, 3'd0);
        queue_sample(12345);
        queue_sample(-32768);
        drain();

        // count above the section total clamps; state kept across writes
        write_reg(cbq_pkg::REG_SECTION_COUNT, 3'd7);
        write_reg(cbq_pkg::REG_CLEAR_ON_WRITE, 3'd0);
        write_reg(REG_SPARE_LO, 3'd5);
        write_reg(REG_SPARE_HI, 3'd2);
        queue_coef(0, cbq_pkg::SLOT_B0, 8388607);
        queue_coef(0, cbq_pkg::SLOT_A1, -8388608);
        queue_coef(1, cbq_pkg::SLOT_B1, -8388608);
        queue_coef(2, cbq_pkg::SLOT_B2, 8388607);
        queue_coef(3, cbq_pkg::SLOT_A2, 524288);
        queue_coef(1, SLOT_BAD_LO, 8388607);
        queue_coef(2, SLOT_BAD_HI, -8388608);
        queue_sample(32767);
        queue_sample(-32768);
        queue_sample(32767);
        queue_sample(100);
        queue_sample(-100);
        drain();

        // clearing write zeroes the section's delay pair
        write_reg(cbq_pkg::REG_CLEAR_ON_WRITE, 3'd1);
        queue_coef(0, cbq_pkg::SLOT_A1, 0);
        queue_coef(3, cbq_pkg::SLOT_B0, -1048576);
        queue_sample(0);
        queue_sample(1);
        drain();

        while (fed < RANDOM_ITEMS)
        begin
            if (fed >= RANDOM_ITEMS - 60)
                calm = 1'b1;
            r = $urandom_range(0, 9);
            cnt = (r < 7) ? $urandom_range(1, SECS) : (r == 7) ? 0 : $urandom_range(5, 7);
            write_reg(cbq_pkg::REG_SECTION_COUNT, DAT_W'(cnt));
            write_reg(cbq_pkg::REG_CLEAR_ON_WRITE, DAT_W'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) != 0)
            begin
                for (s = 0; s < SECS; s++)
                begin
                    if ($urandom_range(0, 2) != 0)
                    begin
                        program_section(s);
                        fed += NSLOTS;
                    end
                end
                repeat ($urandom_range(25, 45))
                begin
                    if ($urandom_range(0, 19) == 0)
                        fed += noise_item();
                    else
                    begin
                        queue_sample(pick_sample());
                        fed++;
                    end
                end
            end
            else
            begin
                repeat (40)
                    fed += noise_item();
            end
            drain();
        end

        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
